FILE: rtl/core/bfwp_pkg.sv
// Shared types and constants for the best-fit workspace pool.
package bfwp_pkg;

    localparam int SIZE_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED   = 3'd0,
        ST_NEW      = 3'd1,
        ST_NONE     = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_BAD      = 3'd5
    } status_t;

endpackage

FILE: rtl/core/bfwp_req_if.sv
// Request channel of the workspace pool: mode, size and slot index.
interface bfwp_req_if;
    import bfwp_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] request_size;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output mode, output request_size, output slot_index,
                    input ready);
    modport sink   (input valid, input mode, input request_size, input slot_index,
                    output ready);
endinterface

FILE: rtl/core/bfwp_rsp_if.sv
// Response channel of the workspace pool: slot, capacity and status.
interface bfwp_rsp_if;
    import bfwp_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [SIZE_W-1:0]   slot_capacity;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output slot, output slot_capacity, output status,
                    input ready);
    modport sink   (input valid, input slot, input slot_capacity, input status,
                    output ready);
endinterface

FILE: rtl/core/best_fit_workspace_pool.sv
// Top level of the best-fit workspace pool: sequencer, scan compare unit, free marks.
//
// Usage: requests arrive on req (valid/ready). mode selects acquire or release.
// An acquire with a nonzero request_size scans the slots in use one per cycle
// through the capacity memory and keeps the smallest free capacity that fits,
// lowest index first on ties. The winner is marked busy; with no fit a new slot
// of the requested size is appended, or status reports a full pool.
// A release frees slot_index, or reports a bad index when it is not in use.
// Each request yields exactly one response on rsp (valid/ready).
// An acquire goes through the scan, then the finish state; a release
// reads the freed slot's capacity, then finishes; a zero-size acquire
// or a bad release index goes straight to the finish state. The scan
// runs through the single memory read port; one request is in flight
// at a time and req.ready is high only while idle; the next request is
// taken in the cycle after the response register loads.
// The response sits in an output register: a new request is accepted while an
// untaken response waits, and the sequencer holds its result until rsp frees up.
// Reset clears the slot count, all free marks and the response valid; capacity
// memory contents need no clearing since only appended slots are ever read.
module best_fit_workspace_pool #(
    parameter int SLOTS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    bfwp_req_if.sink   req,
    bfwp_rsp_if.source rsp
);
    import bfwp_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOTS-1:0]    free_reg, free_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]   best_cap_reg, best_cap_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [SIZE_W-1:0]   res_cap_reg, res_cap_next;
    status_t             res_status_reg, res_status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]   rsp_slot_reg, rsp_slot_next;
    logic [SIZE_W-1:0]   rsp_cap_reg, rsp_cap_next;
    status_t             rsp_status_reg, rsp_status_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [SIZE_W-1:0]   mem_rdata;

    logic [WIDE_W-1:0]   req_idx_wide;
    logic [IDX_W-1:0]    req_idx;
    logic                req_bad;
    logic [WIDE_W-1:0]   best_wide;
    logic [WIDE_W-1:0]   count_wide;
    logic                fits;
    logic                better;
    logic                scan_more;
    logic                rsp_free;

    bfwp_cap_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_cap_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (size_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_idx_wide = WIDE_W'(req.slot_index);
    assign req_idx      = req_idx_wide[IDX_W-1:0];
    assign req_bad      = CMP_W'(req.slot_index) >= CMP_W'(count_reg);
    assign best_wide    = WIDE_W'(best_idx_reg);
    assign count_wide   = WIDE_W'(count_reg);

    // scan compare unit
    assign fits      = free_reg[chk_idx_reg] && (size_reg <= mem_rdata);
    assign better    = !found_reg || (mem_rdata < best_cap_reg);
    assign scan_more = scan_idx_reg < count_reg;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.slot      = rsp_slot_reg;
    assign rsp.slot_capacity = rsp_cap_reg;
    assign rsp.status    = rsp_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        size_next       = size_reg;
        scan_idx_next   = scan_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_cap_next   = best_cap_reg;
        res_slot_next   = res_slot_reg;
        res_cap_next    = res_cap_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_slot_next   = rsp_slot_reg;
        rsp_cap_next    = rsp_cap_reg;
        rsp_status_next = rsp_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_re          = 1'b0;
        mem_raddr       = scan_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    size_next = req.request_size;
                    if (req.mode == MODE_RELEASE)
                    begin
                        res_slot_next = req.slot_index;
                        if (req_bad)
                        begin
                            res_cap_next    = '0;
                            res_status_next = ST_BAD;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            free_next[req_idx] = 1'b1;
                            mem_re             = 1'b1;
                            mem_raddr          = req_idx;
                            res_status_next    = ST_RELEASED;
                            state_next         = S_READ;
                        end
                    end
                    else if (req.request_size == '0)
                    begin
                        res_slot_next   = '0;
                        res_cap_next    = '0;
                        res_status_next = ST_NONE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        best_idx_next = '0;
                        best_cap_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_more)
                begin
                    mem_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                if (chk_valid_reg && fits && better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = chk_idx_reg;
                    best_cap_next = mem_rdata;
                end
                if (!scan_more && !chk_valid_reg)
                begin
                    state_next = S_FINISH;
                    if (found_reg)
                    begin
                        free_next[best_idx_reg] = 1'b0;
                        res_slot_next   = best_wide[SLOT_W-1:0];
                        res_cap_next    = best_cap_reg;
                        res_status_next = ST_REUSED;
                    end
                    else if (CMP_W'(count_reg) >= CMP_W'(SLOTS))
                    begin
                        res_slot_next   = '0;
                        res_cap_next    = '0;
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_slot_next   = count_wide[SLOT_W-1:0];
                        res_cap_next    = size_reg;
                        res_status_next = ST_NEW;
                    end
                end
            end

            S_READ:
            begin
                res_cap_next = mem_rdata;
                state_next   = S_FINISH;
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_slot_next   = res_slot_reg;
                    rsp_cap_next    = res_cap_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_reg      <= '0;
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_cap_reg   <= best_cap_next;
        res_slot_reg   <= res_slot_next;
        res_cap_reg    <= res_cap_next;
        res_status_reg <= res_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_cap_reg    <= rsp_cap_next;
        rsp_status_reg <= rsp_status_next;
    end

endmodule

FILE: rtl/core/bfwp_cap_mem.sv
// Capacity table: one write port, one read port with registered data.
module bfwp_cap_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [bfwp_pkg::SIZE_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [bfwp_pkg::SIZE_W-1:0] rdata
);
    import bfwp_pkg::*;

    logic [SIZE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
